FILE: rtl/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, reset excluded
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CHK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gca_pkg.sv
`default_nettype none

package gca_pkg;

   localparam int GCA_ROWS = 64;
   localparam int GCA_COLS = 64;

   localparam int ROW_W = 6;
   localparam int COL_W = 6;
   localparam int VAL_W = 16;
   localparam int SUM_W = 28;
   localparam int MARK_W = 2;
   localparam int LIM_W = 11;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // queue depth must stay a power of two
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_ROW = 2'd1;
   localparam logic [MARK_W-1:0] MARK_COL = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD_ROW = 2'd0,
      OP_LOAD_COL = 2'd1,
      OP_OFFER = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic idx_ok;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic dir;
      logic [VAL_W-1:0] weight;
      logic [VAL_W-1:0] reward;
      logic [VAL_W-1:0] budget;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

   typedef struct packed {
      logic accepted;
      logic [MARK_W-1:0] mark;
      logic [VAL_W-1:0] remaining;
      logic [SUM_W-1:0] total;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/gca_front.sv
`default_nettype none
`include "assert_macros.svh"

module gca_front
   import gca_pkg::*;
#(
   parameter int ROWS = GCA_ROWS,
   parameter int COLS = GCA_COLS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [63:0] req_tdata,
   input wire logic [1:0] req_tuser,
   input wire back_stat_type stat,
   output logic head_valid,
   output cmd_type head
);

   localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(ROWS);
   localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(COLS);

   cmd_type q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   cmd_type cmd;
   logic push;
   logic row_ok;
   logic col_ok;

   // classify the request
   always_comb begin
      cmd.op = op_type'(req_tuser);
      cmd.row = req_tdata[5:0];
      cmd.col = req_tdata[11:6];
      cmd.dir = req_tdata[12];
      cmd.weight = req_tdata[28:13];
      cmd.reward = req_tdata[44:29];
      cmd.budget = req_tdata[60:45];
      row_ok = LIM_W'(cmd.row) < ROW_LIM;
      col_ok = LIM_W'(cmd.col) < COL_LIM;
      case (cmd.op)
         OP_LOAD_ROW: begin
            cmd.idx_ok = row_ok;
         end
         OP_LOAD_COL: begin
            cmd.idx_ok = col_ok;
         end
         default: begin
            cmd.idx_ok = row_ok && col_ok;
         end
      endcase
   end

   assign req_tready = (count_ff != Q_CNT_W'(Q_DEPTH)) && !stat.clearing;
   assign push = req_tvalid && req_tready;
   assign head_valid = count_ff != '0;
   assign head = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = stat.pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !stat.pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (!push && stat.pop) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_RST(a_queue_bound, clock, reset, count_ff <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
   `ASSERT_RST(a_queue_grow, clock, reset, (push && !stat.pop) |=> count_ff == $past(count_ff) + Q_CNT_W'(1), "queue count lost a push")

endmodule

`default_nettype wire

FILE: rtl/gca_back.sv
`default_nettype none
`include "assert_macros.svh"

module gca_back
   import gca_pkg::*;
#(
   parameter int ROWS = GCA_ROWS,
   parameter int COLS = GCA_COLS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire cmd_type head,
   output back_stat_type stat,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output result_type rsp
);

   localparam int CELLS = ROWS * COLS;
   localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int CADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [CADDR_W-1:0] CLR_LAST = CADDR_W'(CELLS - 1);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_FETCH = 3'b010,
      S_EVAL = 3'b100
   } back_state_type;

   logic [VAL_W-1:0] row_mem [ROWS];
   logic [VAL_W-1:0] col_mem [COLS];
   logic [MARK_W-1:0] mark_mem [CELLS];

   back_state_type state_ff, state_in;
   logic [CADDR_W-1:0] clr_ff, clr_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   cmd_type cur_ff;
   logic [CADDR_W-1:0] addr_ff;
   logic [VAL_W-1:0] row_rd_ff;
   logic [VAL_W-1:0] col_rd_ff;
   logic [MARK_W-1:0] mark_rd_ff;

   logic fetch;
   logic commit;
   logic out_free;
   logic [CADDR_W-1:0] head_addr;
   logic [VAL_W-1:0] bud;
   logic [VAL_W-1:0] bud_left;
   logic admit;
   logic [MARK_W-1:0] mark_new;
   logic [SUM_W:0] sum_wide;
   logic [SUM_W-1:0] sum_sat;
   result_type res;
   logic row_we;
   logic col_we;
   logic [VAL_W-1:0] row_wdata;
   logic [VAL_W-1:0] col_wdata;
   logic mark_we;
   logic [CADDR_W-1:0] mark_waddr;
   logic [MARK_W-1:0] mark_wdata;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fetch = (state_ff == S_FETCH) && head_valid;
   assign commit = (state_ff == S_EVAL) && out_free;
   assign stat = '{pop: fetch, clearing: (state_ff == S_CLEAR)};
   assign head_addr = CADDR_W'(head.row) * CADDR_W'(COLS) + CADDR_W'(head.col);

   // offer evaluation and response fields for every mode
   always_comb begin
      bud = cur_ff.dir ? col_rd_ff : row_rd_ff;
      bud_left = bud - cur_ff.weight;
      admit = (cur_ff.op == OP_OFFER) && cur_ff.idx_ok && (bud != '0) &&
              (cur_ff.weight <= bud) && (mark_rd_ff == MARK_NONE);
      mark_new = cur_ff.dir ? MARK_COL : MARK_ROW;
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(cur_ff.reward);
      sum_sat = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      sum_in = (commit && admit) ? sum_sat : sum_ff;
      res.accepted = 1'b0;
      res.mark = MARK_NONE;
      res.remaining = '0;
      res.total = sum_in;
      case (cur_ff.op)
         OP_LOAD_ROW, OP_LOAD_COL: begin
            if (cur_ff.idx_ok) begin
               res.accepted = 1'b1;
               res.remaining = cur_ff.budget;
            end
         end
         OP_OFFER: begin
            if (cur_ff.idx_ok) begin
               res.accepted = admit;
               res.mark = admit ? mark_new : mark_rd_ff;
               res.remaining = admit ? bud_left : bud;
            end
         end
         default: begin
            if (cur_ff.idx_ok) begin
               res.mark = mark_rd_ff;
            end
         end
      endcase
   end

   // memory write ports
   always_comb begin
      row_we = 1'b0;
      col_we = 1'b0;
      row_wdata = cur_ff.budget;
      col_wdata = cur_ff.budget;
      if (commit && cur_ff.idx_ok) begin
         case (cur_ff.op)
            OP_LOAD_ROW: begin
               row_we = 1'b1;
            end
            OP_LOAD_COL: begin
               col_we = 1'b1;
            end
            OP_OFFER: begin
               row_we = admit && !cur_ff.dir;
               col_we = admit && cur_ff.dir;
               row_wdata = bud_left;
               col_wdata = bud_left;
            end
            default: begin
               row_we = 1'b0;
            end
         endcase
      end
      if (state_ff == S_CLEAR) begin
         mark_we = 1'b1;
         mark_waddr = clr_ff;
         mark_wdata = MARK_NONE;
      end else begin
         mark_we = commit && admit;
         mark_waddr = addr_ff;
         mark_wdata = mark_new;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (head_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               state_in = S_FETCH;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[RIDX_W'(cur_ff.row)] <= row_wdata;
      end
      if (col_we) begin
         col_mem[CIDX_W'(cur_ff.col)] <= col_wdata;
      end
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         row_rd_ff <= row_mem[RIDX_W'(head.row)];
         col_rd_ff <= col_mem[CIDX_W'(head.col)];
         mark_rd_ff <= mark_mem[head_addr];
         cur_ff <= head;
         addr_ff <= head_addr;
      end
      if (commit) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `ASSERT_RST(a_pop_has_head, clock, reset, stat.pop |-> head_valid, "pop from empty queue")
   `ASSERT_RST(a_eval_holds, clock, reset, (state_ff == S_EVAL && !out_free) |=> state_ff == S_EVAL, "result dropped while output busy")
   `ASSERT_RST(a_sum_monotone, clock, reset, !$past(reset) |-> sum_ff >= $past(sum_ff), "reward total decreased")

endmodule

`default_nettype wire

FILE: rtl/greedy_capacity_admission.sv
`default_nettype none

// Greedy admission of cell offers against per-row and per-column budgets. After reset the
// block sweeps the cell mark memory, one cell per cycle, over all ROWS*COLS cells (4096 with
// the default size); req_tready stays low during that sweep. Afterwards each request passes
// through the back-end states S_FETCH, for the registered reads of the row budget, column
// budget and cell mark memories, and then S_EVAL, to evaluate, write back and load the response
// register; S_EVAL waits while the output is busy, and the next request is fetched only after
// that. A two-entry queue takes requests while a response waits. Budgets are undefined until
// loaded; an offer against an unloaded budget gives an undefined response.
module greedy_capacity_admission
   import gca_pkg::*;
#(
   parameter int ROWS = GCA_ROWS,
   parameter int COLS = GCA_COLS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [63:0] req_tdata,  // row, col, direction, weight, reward, budget_value
   input wire logic [1:0] req_tuser,   // mode
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [47:0] rsp_tdata       // accepted, cell_mark, remaining_budget, total_reward
);

   back_stat_type stat;
   logic head_valid;
   cmd_type head;
   result_type rsp;

   gca_front #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .stat(stat),
      .head_valid(head_valid),
      .head(head)
   );

   gca_back #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head(head),
      .stat(stat),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp(rsp)
   );

   assign rsp_tdata = {1'b0, rsp.total, rsp.remaining, rsp.mark, rsp.accepted};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
   import gca_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_REQUESTS = 900;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      op_type op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic dir;
      logic [VAL_W-1:0] weight;
      logic [VAL_W-1:0] reward;
      logic [VAL_W-1:0] budget;
      bit settle;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_QUERY;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   request_type request_backlog[$];
   result_type expected_verdicts[$];
   request_type on_bus;

   // testbench copy of the admission state
   logic [VAL_W-1:0] row_cap[GCA_ROWS];
   logic [VAL_W-1:0] col_cap[GCA_COLS];
   logic [MARK_W-1:0] cell_mark[GCA_ROWS][GCA_COLS];
   logic [SUM_W-1:0] reward_total = '0;

   // which budgets the generator has loaded so far
   bit row_set[GCA_ROWS];
   bit col_set[GCA_COLS];

   int mismatches = 0;
   int cycle_count = 0;
   int stall_count = 0;

   greedy_capacity_admission uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      foreach (cell_mark[r, c]) cell_mark[r][c] = MARK_NONE;
   end

   function automatic result_type judge_request(input request_type rq);
      result_type v;
      logic [VAL_W-1:0] cap;
      logic [SUM_W:0] sum;
      v = '0;
      case (rq.op)
         OP_LOAD_ROW: begin
            row_cap[rq.row] = rq.budget;
            v.accepted = 1'b1;
            v.remaining = rq.budget;
         end
         OP_LOAD_COL: begin
            col_cap[rq.col] = rq.budget;
            v.accepted = 1'b1;
            v.remaining = rq.budget;
         end
         OP_OFFER: begin
            cap = rq.dir ? col_cap[rq.col] : row_cap[rq.row];
            v.mark = cell_mark[rq.row][rq.col];
            if (cap != 0 && rq.weight <= cap && v.mark == MARK_NONE) begin
               v.mark = rq.dir ? MARK_COL : MARK_ROW;
               cell_mark[rq.row][rq.col] = v.mark;
               cap = cap - rq.weight;
               if (rq.dir) begin
                  col_cap[rq.col] = cap;
               end else begin
                  row_cap[rq.row] = cap;
               end
               sum = reward_total + rq.reward;
               reward_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
               v.accepted = 1'b1;
            end
            v.remaining = cap;
         end
         default: begin
            v.mark = cell_mark[rq.row][rq.col];
         end
      endcase
      v.total = reward_total;
      return v;
   endfunction

   function automatic logic [63:0] pack_request(input request_type rq);
      return {3'b000, rq.budget, rq.reward, rq.weight, rq.dir, rq.col, rq.row};
   endfunction

   task automatic add_request(input op_type op, input int row, input int col, input bit dir,
                              input int weight, input int reward, input int budget,
                              input bit settle = 1'b0);
      request_type rq;
      rq.op = op;
      rq.row = row[ROW_W-1:0];
      rq.col = col[COL_W-1:0];
      rq.dir = dir;
      rq.weight = weight[VAL_W-1:0];
      rq.reward = reward[VAL_W-1:0];
      rq.budget = budget[VAL_W-1:0];
      rq.settle = settle;
      if (op == OP_LOAD_ROW) row_set[rq.row] = 1'b1;
      if (op == OP_LOAD_COL) col_set[rq.col] = 1'b1;
      request_backlog.push_back(rq);
   endtask

   // most cells come from a small corner so marks and budgets get reused
   function automatic int pick_index();
      return ($urandom_range(99, 0) < 60) ? $urandom_range(7, 0) : $urandom_range(63, 0);
   endfunction

   function automatic int pick_value();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 10) return 0;
      if (roll < 20) return 16'hffff;
      if (roll < 55) return $urandom_range(15, 0);
      return $urandom_range(65535, 0);
   endfunction

   // stimulus
   initial begin
      int row;
      int col;
      int roll;
      bit dir;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_request(OP_QUERY, 0, 0, 0, 0, 0, 0);
      add_request(OP_LOAD_ROW, 0, 0, 0, 0, 0, 16'hffff);
      add_request(OP_LOAD_COL, 0, 63, 0, 0, 0, 0);
      add_request(OP_LOAD_ROW, 63, 0, 0, 0, 0, 1);
      add_request(OP_LOAD_COL, 0, 0, 0, 0, 0, 100);
      add_request(OP_OFFER, 0, 0, 0, 16'hffff, 16'hffff, 0);
      add_request(OP_OFFER, 0, 1, 0, 0, 5, 0);
      add_request(OP_OFFER, 0, 63, 1, 0, 5, 0);
      add_request(OP_OFFER, 63, 5, 0, 2, 7, 0);
      add_request(OP_OFFER, 63, 5, 0, 0, 7, 0);
      add_request(OP_OFFER, 63, 6, 0, 1, 9, 0);
      add_request(OP_OFFER, 0, 0, 1, 1, 3, 0);
      add_request(OP_OFFER, 10, 0, 1, 100, 1, 0);
      add_request(OP_QUERY, 10, 0, 0, 0, 0, 0);
      add_request(OP_QUERY, 0, 0, 0, 0, 0, 0);
      add_request(OP_QUERY, 63, 63, 1, 0, 0, 0);
      add_request(OP_LOAD_ROW, 31, 0, 0, 0, 0, 16'h5555);
      add_request(OP_LOAD_COL, 0, 42, 0, 0, 0, 16'haaaa);
      add_request(OP_OFFER, 31, 42, 0, 16'h5555, 16'haaaa, 0);
      add_request(OP_OFFER, 30, 42, 1, 16'haaaa, 16'h5555, 0, 1'b1);
      add_request(OP_OFFER, 42, 42, 1, 16'haaab, 16'h5555, 0);
      add_request(OP_QUERY, 31, 42, 0, 0, 0, 0);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         row = pick_index();
         col = pick_index();
         dir = $urandom_range(1, 0);
         roll = $urandom_range(99, 0);
         if (roll < 10) begin
            add_request(OP_LOAD_ROW, row, $urandom_range(63, 0), dir, $urandom_range(65535, 0),
                        $urandom_range(65535, 0), pick_value(), n % 250 == 249);
         end else if (roll < 20) begin
            add_request(OP_LOAD_COL, $urandom_range(63, 0), col, dir, $urandom_range(65535, 0),
                        $urandom_range(65535, 0), pick_value(), n % 250 == 249);
         end else if (roll < 80) begin
            // budgets that were never loaded must not be read
            if (!dir && !row_set[row]) begin
               add_request(OP_LOAD_ROW, row, col, 0, 0, 0, pick_value());
            end
            if (dir && !col_set[col]) begin
               add_request(OP_LOAD_COL, row, col, 0, 0, 0, pick_value());
            end
            add_request(OP_OFFER, row, col, dir, pick_value(), $urandom_range(65535, 0),
                        $urandom_range(65535, 0), n % 250 == 249);
         end else begin
            add_request(OP_QUERY, row, col, dir, $urandom_range(65535, 0),
                        $urandom_range(65535, 0), $urandom_range(65535, 0), n % 250 == 249);
         end
      end

      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_verdicts.push_back(judge_request(on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0
                && ((cycle_count >= 5000 && cycle_count < 6000)
                    || $urandom_range(99, 0) >= 16)
                && !(request_backlog[0].settle && expected_verdicts.size() != 0)) begin
               on_bus = request_backlog.pop_front();
               req_tdata <= pack_request(on_bus);
               req_tuser <= on_bus.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count >= 5000 && cycle_count < 6000)
                       || $urandom_range(99, 0) >= 16;
         if (rsp_tvalid && rsp_tready) begin
            got.accepted = rsp_tdata[0];
            got.mark = rsp_tdata[2:1];
            got.remaining = rsp_tdata[18:3];
            got.total = rsp_tdata[46:19];
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("unexpected response: accepted %0d mark %0d remaining %0d total %0d",
                           got.accepted, got.mark, got.remaining, got.total);
               end
            end else begin
               want = expected_verdicts.pop_front();
               if (got.accepted !== want.accepted || got.mark !== want.mark
                   || got.remaining !== want.remaining || got.total !== want.total) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("response mismatch: accepted %0d/%0d mark %0d/%0d",
                              want.accepted, got.accepted, want.mark, got.mark,
                              " remaining %0d/%0d total %0d/%0d (expected/actual)",
                              want.remaining, got.remaining, want.total, got.total);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

endmodule

`default_nettype wire
